/* rtl/core/csvd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the csv line decoder
package csvd_pkg;

  // parse modes
  localparam logic [2:0] MODE_CELL   = 3'd0;
  localparam logic [2:0] MODE_RAW    = 3'd1;
  localparam logic [2:0] MODE_QUOTED = 3'd2;
  localparam logic [2:0] MODE_QSEEN  = 3'd3;
  localparam logic [2:0] MODE_CR     = 3'd4;

  // result kinds
  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_CELL = 2'd1;
  localparam logic [1:0] EV_LINE = 2'd2;
  localparam logic [1:0] EV_EOS  = 2'd3;

  // fixed special bytes
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // configuration register indexes
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_val;
  } ev_t;

  typedef struct packed {
    logic [1:0] n;
    ev_t        ev0;
    ev_t        ev1;
    logic [2:0] mode_next;
    logic       touched_next;
  } dec_t;

endpackage

/* rtl/core/csvd_decode.sv */
`timescale 1ns / 1ps
// per-byte parse step: results and next parse state
module csvd_decode #(
  parameter int OFFSET_BITS = 16
) (
  input  logic [2:0]             mode,
  input  logic [OFFSET_BITS-1:0] count,
  input  logic                   touched,
  input  logic [7:0]             data_byte,
  input  logic                   stream_end,
  input  logic [7:0]             separator_char,
  input  logic [7:0]             quote_char,
  output csvd_pkg::dec_t         dec,
  output logic [OFFSET_BITS-1:0] count_next,
  output logic [OFFSET_BITS-1:0] offset
);
  import csvd_pkg::*;

  logic       f_cell;
  logic       f_char;
  logic       f_line;
  logic       f_eos;
  logic       close;
  logic [7:0] char_v;
  logic [2:0] mode_n;
  logic       touched_n;

  always_comb begin
    f_cell     = 1'b0;
    f_char     = 1'b0;
    f_line     = 1'b0;
    f_eos      = 1'b0;
    close      = 1'b0;
    char_v     = data_byte;
    mode_n     = mode;
    touched_n  = touched;
    count_next = count;
    if (stream_end) begin
      if (!touched) begin
        f_eos = 1'b1;
      end else begin
        close = 1'b1;
      end
    end else begin
      touched_n = 1'b1;
      case (mode)
        MODE_CELL: begin
          if (data_byte == separator_char) begin
            f_cell = 1'b1;
          end else if (data_byte == quote_char) begin
            mode_n = MODE_QUOTED;
            f_cell = 1'b1;
          end else if (data_byte == CH_CR) begin
            mode_n = MODE_CR;
            f_cell = 1'b1;
          end else if (data_byte == CH_LF) begin
            close = 1'b1;
          end else begin
            mode_n = MODE_RAW;
            f_cell = 1'b1;
            f_char = 1'b1;
          end
        end
        MODE_RAW: begin
          if (data_byte == separator_char) begin
            mode_n = MODE_CELL;
          end else if (data_byte == CH_CR) begin
            mode_n = MODE_CR;
          end else if (data_byte == CH_LF) begin
            close = 1'b1;
          end else begin
            f_char = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (data_byte == quote_char) begin
            mode_n = MODE_QSEEN;
          end else begin
            f_char = 1'b1;
          end
        end
        MODE_QSEEN: begin
          if (data_byte == quote_char) begin
            mode_n = MODE_QUOTED;
            f_char = 1'b1;
            char_v = quote_char;
          end else if (data_byte == separator_char) begin
            mode_n = MODE_CELL;
          end else if (data_byte == CH_CR) begin
            mode_n = MODE_CR;
          end else if (data_byte == CH_LF) begin
            close = 1'b1;
          end else begin
            mode_n = MODE_QUOTED;
            f_char = 1'b1;
          end
        end
        default: begin
          // after cr: lf ends the line, anything else is dropped
          if (data_byte == CH_LF) begin
            close = 1'b1;
          end else begin
            mode_n = MODE_RAW;
          end
        end
      endcase
    end

    if (close) begin
      f_cell = f_cell | (mode == MODE_CELL);
      f_line = 1'b1;
    end

    if (f_char && (count != {OFFSET_BITS{1'b1}})) begin
      count_next = count + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    end

    if (close || f_eos) begin
      mode_n     = MODE_CELL;
      count_next = '0;
      touched_n  = 1'b0;
    end
  end

  // every result of one byte carries the count from before that byte
  assign offset = f_eos ? '0 : count;

  always_comb begin
    dec.n = {1'b0, f_cell} + {1'b0, f_char} + {1'b0, f_line} + {1'b0, f_eos};
    if (f_cell) begin
      dec.ev0.kind = EV_CELL;
    end else if (f_char) begin
      dec.ev0.kind = EV_CHAR;
    end else if (f_line) begin
      dec.ev0.kind = EV_LINE;
    end else begin
      dec.ev0.kind = EV_EOS;
    end
    dec.ev0.char_val = (!f_cell && f_char) ? char_v : 8'd0;
    dec.ev1.kind     = f_line ? EV_LINE : EV_CHAR;
    dec.ev1.char_val = f_char ? char_v : 8'd0;
    dec.mode_next    = mode_n;
    dec.touched_next = touched_n;
  end

endmodule

/* rtl/core/csvd_out_buf.sv */
`timescale 1ns / 1ps
// two-entry result buffer that drains one result per cycle while the receiver is ready
module csvd_out_buf #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  csvd_pkg::dec_t         dec,
  input  logic [OFFSET_BITS-1:0] offset,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             event_kind,
  output logic [7:0]             char_value,
  output logic [OFFSET_BITS-1:0] line_offset,
  output logic                   last_of_run
);
  import csvd_pkg::*;

  logic [1:0]             cnt;
  ev_t                    r0;
  ev_t                    r1;
  logic [OFFSET_BITS-1:0] off;
  logic                   take;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && out_ready;
  assign free      = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= dec.n;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0  <= dec.ev0;
      r1  <= dec.ev1;
      off <= offset;
    end else if (take) begin
      r0 <= r1;
    end
  end

  assign event_kind  = r0.kind;
  assign char_value  = r0.char_val;
  assign line_offset = off;
  assign last_of_run = (cnt == 2'd1);

endmodule

/* rtl/core/csv_line_decoder.sv */
`timescale 1ns / 1ps
// csv line decoder top level: input register, parse state, result buffer
// an accepted item is held in the input register, then its results are registered in the result buffer
// throughput: one item per cycle while each item gives at most one result and the receiver is ready;
// an item with two results holds the result buffer until both results have been taken
// reset: synchronous, active high; parse state returns to cell start with a
// zero count, separator and quote return to comma and double quote
module csv_line_decoder #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [7:0]             wr_data,
  // input items
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   stream_end,
  // result items
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             event_kind,
  output logic [7:0]             char_value,
  output logic [OFFSET_BITS-1:0] line_offset,
  output logic                   last_of_run
);
  import csvd_pkg::*;

  // configuration registers
  logic [7:0] separator_char;
  logic [7:0] quote_char;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_end;

  // parse state
  logic [2:0]             mode;
  logic [OFFSET_BITS-1:0] count;
  logic                   touched;

  // decode results
  dec_t                   dec;
  logic [OFFSET_BITS-1:0] count_next;
  logic [OFFSET_BITS-1:0] offset;
  logic                   buf_free;
  logic                   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEPARATOR_RESET;
      quote_char     <= QUOTE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SEPARATOR: separator_char <= wr_data;
        REG_QUOTE:     quote_char     <= wr_data;
        default:       separator_char <= separator_char;
      endcase
    end
  end

  // the held item moves on once the result buffer can take all its results
  assign advance  = in_q_valid && buf_free;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_byte <= data_byte;
      in_q_end  <= stream_end;
    end
  end

  // one parse step per held item
  csvd_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .mode          (mode),
    .count         (count),
    .touched       (touched),
    .data_byte     (in_q_byte),
    .stream_end    (in_q_end),
    .separator_char(separator_char),
    .quote_char    (quote_char),
    .dec           (dec),
    .count_next    (count_next),
    .offset        (offset)
  );

  // state moves together with the item leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_CELL;
      count   <= '0;
      touched <= 1'b0;
    end else if (advance) begin
      mode    <= dec.mode_next;
      count   <= count_next;
      touched <= dec.touched_next;
    end
  end

  // results wait here so the next item can be taken meanwhile
  csvd_out_buf #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .dec        (dec),
    .offset     (offset),
    .free       (buf_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .char_value (char_value),
    .line_offset(line_offset),
    .last_of_run(last_of_run)
  );

`ifndef ASSERT_OFF
  // a line end is always the final result of its item
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_LINE) |-> last_of_run)
    else $error("line end not marked last");

  // the first of a result pair is always a cell start
  a_pair_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> (event_kind == EV_CELL))
    else $error("first of pair is not a cell start");

  // end of stream leaves a fresh line behind
  a_end_fresh: assert property (@(posedge clk) disable iff (rst)
    advance && in_q_end |=> (mode == MODE_CELL) && (count == '0) && !touched)
    else $error("state not cleared after end of stream");

  // empty stream end carries zero offset
  a_eos_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_EOS) |-> (line_offset == '0))
    else $error("end of stream with non-zero offset");
`endif

endmodule

/* bench/csv_line_decoder_checker.sv */
`timescale 1ns / 1ps
// result checker for the csv line decoder: predicts results of accepted items and compares
module csvd_result_checker #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [7:0]             wr_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   stream_end,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             event_kind,
  input  logic [7:0]             char_value,
  input  logic [OFFSET_BITS-1:0] line_offset,
  input  logic                   last_of_run,
  output int                     error_count,
  output int                     pending,
  output int                     results_checked,
  output int                     lines_closed
);
  import csvd_pkg::*;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             ch;
    logic [OFFSET_BITS-1:0] off;
    logic                   last;
  } parse_event_t;

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  parse_event_t           expected_events[$];
  parse_event_t           step_events[2];
  int                     step_n;

  // own copy of the parser state and the registers
  logic [2:0]             mode;
  logic [OFFSET_BITS-1:0] decoded;
  logic                   touched;
  logic [7:0]             sep_char;
  logic [7:0]             quote_char;

  int mismatches = 0;
  int checked    = 0;
  int closed     = 0;

  task automatic add_event(input logic [1:0] ev_kind, input logic [7:0] ev_char,
                           input logic [OFFSET_BITS-1:0] ev_off);
    if (step_n < 2) begin
      step_events[step_n] = '{kind: ev_kind, ch: ev_char, off: ev_off, last: 1'b0};
      step_n++;
    end
  endtask

  task automatic add_content(input logic [7:0] ev_char);
    add_event(EV_CHAR, ev_char, decoded);
    if (decoded != COUNT_MAX) decoded++;
  endtask

  task automatic restart_line;
    mode    = MODE_CELL;
    decoded = '0;
    touched = 1'b0;
  endtask

  task automatic close_line;
    // a line that ends at a cell start gets an empty final cell
    if (mode == MODE_CELL) add_event(EV_CELL, 8'd0, decoded);
    add_event(EV_LINE, 8'd0, decoded);
    closed++;
    restart_line();
  endtask

  task automatic predict_item(input logic [7:0] b, input logic at_end);
    step_n = 0;
    if (at_end) begin
      if (!touched) begin
        add_event(EV_EOS, 8'd0, '0);
        restart_line();
      end else begin
        close_line();
      end
    end else begin
      touched = 1'b1;
      case (mode)
        MODE_CELL: begin
          if (b == sep_char) begin
            add_event(EV_CELL, 8'd0, decoded);
          end else if (b == quote_char) begin
            mode = MODE_QUOTED;
            add_event(EV_CELL, 8'd0, decoded);
          end else if (b == CH_CR) begin
            mode = MODE_CR;
            add_event(EV_CELL, 8'd0, decoded);
          end else if (b == CH_LF) begin
            close_line();
          end else begin
            mode = MODE_RAW;
            add_event(EV_CELL, 8'd0, decoded);
            add_content(b);
          end
        end
        MODE_RAW: begin
          if (b == sep_char) mode = MODE_CELL;
          else if (b == CH_CR) mode = MODE_CR;
          else if (b == CH_LF) close_line();
          else add_content(b);
        end
        MODE_QUOTED: begin
          if (b == quote_char) mode = MODE_QSEEN;
          else add_content(b);
        end
        MODE_QSEEN: begin
          if (b == quote_char) begin
            mode = MODE_QUOTED;
            add_content(quote_char);
          end else if (b == sep_char) begin
            mode = MODE_CELL;
          end else if (b == CH_CR) begin
            mode = MODE_CR;
          end else if (b == CH_LF) begin
            close_line();
          end else begin
            mode = MODE_QUOTED;
            add_content(b);
          end
        end
        default: begin
          if (b == CH_LF) close_line();
          else mode = MODE_RAW;
        end
      endcase
    end
    if (step_n > 0) step_events[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++)
      expected_events.insert(expected_events.size(), step_events[i]);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  task automatic compare_event(input parse_event_t want);
    if (event_kind !== want.kind)
      note_mismatch("event_kind", 32'(want.kind), 32'(event_kind));
    if (char_value !== want.ch)
      note_mismatch("char_value", 32'(want.ch), 32'(char_value));
    if (line_offset !== want.off)
      note_mismatch("line_offset", 32'(want.off), 32'(line_offset));
    if (last_of_run !== want.last)
      note_mismatch("last_of_run", 32'(want.last), 32'(last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sep_char   = SEPARATOR_RESET;
      quote_char = QUOTE_RESET;
      restart_line();
      expected_events.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_SEPARATOR) sep_char = wr_data;
        else quote_char = wr_data;
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected none, actual kind %0d char %0h",
                   $time, event_kind, char_value);
        end else begin
          compare_event(expected_events.pop_front());
          checked++;
        end
      end
      if (in_valid && in_ready) predict_item(data_byte, stream_end);
    end
    error_count     <= mismatches;
    pending         <= expected_events.size();
    results_checked <= checked;
    lines_closed    <= closed;
  end

endmodule

/* bench/csv_line_decoder_tb.sv */
`timescale 1ns / 1ps
// testbench top for the csv line decoder: stimulus, stalls, verdict
module csv_line_decoder_tb;
  import csvd_pkg::*;

  localparam int OFFSET_BITS = 16;
  localparam int PHASE_ITEMS = 120;
  localparam int N_PHASES    = 7;
  // cycle limit for the watchdog
  localparam int CYCLE_LIMIT = 300_000;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   wr_en       = 1'b0;
  logic                   wr_index    = REG_SEPARATOR;
  logic [7:0]             wr_data     = 8'd0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [7:0]             data_byte   = 8'd0;
  logic                   stream_end  = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [1:0]             event_kind;
  logic [7:0]             char_value;
  logic [OFFSET_BITS-1:0] line_offset;
  logic                   last_of_run;

  int error_count;
  int pending;
  int results_checked;
  int lines_closed;

  int   cycles      = 0;
  int   items_sent  = 0;
  int   phase_items = 0;
  int   out_hold    = 0;
  // no idling on either side once set
  logic quiet       = 1'b0;

  // separator and quote as last written, so the stimulus can build proper lines
  logic [7:0] cur_sep = SEPARATOR_RESET;
  logic [7:0] cur_quo = QUOTE_RESET;

  // settings per phase: defaults, ordinary alternates, both extremes, separator equal to quote,
  // separator and quote on CR and LF, and defaults again
  logic [7:0] sep_table [N_PHASES] = '{SEPARATOR_RESET, 8'h3B, 8'h00, 8'hFF, 8'h7C,
                                       CH_CR, SEPARATOR_RESET};
  logic [7:0] quo_table [N_PHASES] = '{QUOTE_RESET, 8'h27, 8'hFF, 8'h00, 8'h7C,
                                       CH_LF, QUOTE_RESET};

  // directed items under the default settings, bit 8 marks end of stream
  logic [8:0] directed_items [30] = '{
    {1'b1, 8'hA5},            // end of stream before any byte
    {1'b0, 8'h61},            // raw cell: cell start then content
    {1'b0, SEPARATOR_RESET},  // separator closes the raw cell
    {1'b0, SEPARATOR_RESET},  // empty cell
    {1'b0, QUOTE_RESET},      // quoted cell opens
    {1'b0, 8'h78},
    {1'b0, QUOTE_RESET},      // quote seen
    {1'b0, QUOTE_RESET},      // doubled quote gives one quote
    {1'b0, SEPARATOR_RESET},  // separator is content inside quotes
    {1'b0, QUOTE_RESET},
    {1'b0, 8'h7A},            // lone quote dropped, byte kept
    {1'b0, QUOTE_RESET},
    {1'b0, SEPARATOR_RESET},  // separator after closing quote
    {1'b0, CH_CR},            // cell start on CR
    {1'b0, CH_LF},            // CR LF closes the line
    {1'b0, CH_LF},            // bare LF: empty final cell and line end
    {1'b0, 8'h00},            // lowest byte as content
    {1'b0, 8'hFF},            // highest byte as content
    {1'b0, CH_CR},
    {1'b0, 8'h41},            // byte after CR dropped, back to raw
    {1'b0, CH_LF},
    {1'b0, QUOTE_RESET},
    {1'b0, CH_LF},            // LF is content inside quotes
    {1'b1, 8'h5A},            // unterminated quoted cell closed at end of stream
    {1'b0, 8'h62},
    {1'b0, SEPARATOR_RESET},
    {1'b1, 8'h00},            // end of stream at a cell start
    {1'b0, QUOTE_RESET},
    {1'b0, QUOTE_RESET},
    {1'b1, 8'hFF}             // end of stream in quote seen
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csv_line_decoder #(
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .char_value (char_value),
    .line_offset(line_offset),
    .last_of_run(last_of_run)
  );

  csvd_result_checker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) result_check (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .stream_end     (stream_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .char_value     (char_value),
    .line_offset    (line_offset),
    .last_of_run    (last_of_run),
    .error_count    (error_count),
    .pending        (pending),
    .results_checked(results_checked),
    .lines_closed   (lines_closed)
  );

  // watchdog: ends a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, none once quiet
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_hold  <= $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_byte;
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // a byte with no special meaning under the current settings
  function automatic logic [7:0] plain_byte;
    logic [7:0] b;
    b = rand_byte();
    while (b == cur_sep || b == cur_quo || b == CH_CR || b == CH_LF) b = rand_byte();
    return b;
  endfunction

  function automatic logic [7:0] special_byte;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = cur_sep;
      1: b = cur_quo;
      2: b = CH_CR;
      default: b = CH_LF;
    endcase
    return b;
  endfunction

  // offer one item and hold it until accepted; may idle first
  task automatic send_item(input logic [7:0] b, input logic at_end);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    stream_end <= at_end;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    phase_items++;
  endtask

  // stop offering, let every expected result drain, then cover the pipeline
  task automatic drain;
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] sep, input logic [7:0] quo);
    wr_en    <= 1'b1;
    wr_index <= REG_SEPARATOR;
    wr_data  <= sep;
    @(posedge clk);
    wr_index <= REG_QUOTE;
    wr_data  <= quo;
    @(posedge clk);
    wr_en    <= 1'b0;
    @(posedge clk);
    cur_sep = sep;
    cur_quo = quo;
  endtask

  task automatic send_raw_cell;
    repeat ($urandom_range(1, 6)) send_item(plain_byte(), 1'b0);
  endtask

  // quoted cell with doubled quotes, embedded specials and the odd lone quote
  task automatic send_quoted_cell;
    int pick;
    send_item(cur_quo, 1'b0);
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(cur_quo, 1'b0);
        send_item(cur_quo, 1'b0);
      end else if (pick == 1) begin
        send_item(special_byte(), 1'b0);
      end else if (pick == 2) begin
        send_item(cur_quo, 1'b0);
        send_item(plain_byte(), 1'b0);
      end else begin
        send_item(plain_byte(), 1'b0);
      end
    end
    send_item(cur_quo, 1'b0);
  endtask

  // mostly well-formed lines with random content, some raw noise
  task automatic gen_line;
    int shape;
    int cells;
    int kind;
    int ending;
    int i;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1) == 0) send_item(special_byte(), 1'b0);
        else send_item(rand_byte(), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) send_item(rand_byte(), 1'b1);
    end else begin
      cells = $urandom_range(1, 5);
      for (i = 0; i < cells; i++) begin
        if (i > 0) send_item(cur_sep, 1'b0);
        kind = $urandom_range(0, 3);
        if (kind == 1 || kind == 2) send_raw_cell();
        else if (kind == 3) send_quoted_cell();
      end
      ending = $urandom_range(0, 9);
      if (ending <= 5) begin
        send_item(CH_LF, 1'b0);
      end else if (ending <= 7) begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end else if (ending == 8) begin
        // end of stream after a partial line, sometimes a second one on the empty line
        send_item(rand_byte(), 1'b1);
        if ($urandom_range(0, 1) == 0) send_item(rand_byte(), 1'b1);
      end else begin
        // broken line ending: stray byte after CR is dropped
        send_item(CH_CR, 1'b0);
        send_item(plain_byte(), 1'b0);
        send_item(CH_LF, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        // registers change only with nothing in flight
        drain();
        write_config(sep_table[p], quo_table[p]);
      end
      phase_items = 0;
      if (p == 0) begin
        foreach (directed_items[k]) send_item(directed_items[k][7:0], directed_items[k][8]);
        phase_items = 0;
      end
      while (phase_items < PHASE_ITEMS) begin
        // last half of the final phase runs without idling
        if (p == N_PHASES - 1 && phase_items >= PHASE_ITEMS / 2) quiet = 1'b1;
        gen_line();
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d input items over %0d separator and quote settings",
             items_sent, N_PHASES);
    $display("checked %0d results over %0d closed lines", results_checked, lines_closed);
    if (error_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
